[hw/rtl/dsa_pkg.sv]
// Shared types, codes and constants for the descriptor slot allocator.
package dsa_pkg;

    // Command codes
    localparam logic [1:0] CMD_ALLOC     = 2'd0;
    localparam logic [1:0] CMD_FREE_IDX  = 2'd1;
    localparam logic [1:0] CMD_FREE_ADDR = 2'd2;
    localparam logic [1:0] CMD_CLEAR     = 2'd3;

    // Status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_SIZE     = 2'd1;
    localparam logic [1:0] CFG_CPU_BASE = 2'd2;
    localparam logic [1:0] CFG_GPU_BASE = 2'd3;

    // Field widths
    localparam int CAP_W  = 11;
    localparam int SIZE_W = 9;
    localparam int ADDR_W = 64;
    localparam int FIDX_W = 32;
    localparam int SIDX_W = 10;
    localparam int LIVE_W = 11;
    localparam int OFF_W  = 32;

    // Reset values
    localparam logic [CAP_W-1:0]  RST_CAPACITY = 11'd1024;
    localparam logic [SIZE_W-1:0] RST_SIZE     = 9'd32;

    localparam int DEF_MAX_SLOTS = 1024;

    typedef logic [ADDR_W-1:0] t_addr;

endpackage

[hw/rtl/dsa_stack.sv]
// Free stack memory: one write port, one read port, registered read data.
module dsa_stack
    import dsa_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_SLOTS,
    parameter int WIDTH = $clog2(DEF_MAX_SLOTS)
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[hw/rtl/dsa_div.sv]
// Restoring divider, one quotient bit per cycle: 32-bit offset by slot size.
module dsa_div
    import dsa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [OFF_W-1:0]  i_dividend,
    input  logic [SIZE_W-1:0] i_divisor,
    output logic              o_done,
    output logic [OFF_W-1:0]  o_quotient
);

    localparam int CNT_W = $clog2(OFF_W);

    logic              r_run;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [SIZE_W-1:0] r_rem;
    logic [SIZE_W-1:0] r_div;
    logic [OFF_W-1:0]  r_quo;

    logic [SIZE_W:0]   w_trial;
    logic              w_ge;
    logic [SIZE_W:0]   w_diff;

    assign w_trial = {r_rem, r_quo[OFF_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(OFF_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder stays below the divisor, so it fits in SIZE_W bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_run) begin
            r_quo <= {r_quo[OFF_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[SIZE_W-1:0] : w_trial[SIZE_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[hw/rtl/descriptor_slot_allocator_top.sv]
// Descriptor slot allocator: LIFO free stack in memory plus a bump pointer.
//
// A command is taken when i_start is high and o_busy is low; its single result
// word appears on the o_ ports for one cycle with o_valid, and the receiver
// cannot stall it. A free by index, an exhausted allocate, a clear and a free
// by address with a zero slot size are answered from S_IDLE; a fresh allocate
// passes S_MUL and S_OUT, a pop from the free stack S_RD, S_MUL and S_OUT
// (stack memory read, then slot-size multiply, then base add); other frees by
// GPU address wait in S_DIV for the one-bit-per-cycle divider. o_busy is low
// again in the cycle the result is shown, so the next command may be accepted
// then. Configuration must be written only while idle, which is not enforced.
module descriptor_slot_allocator_top
    import dsa_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [ADDR_W-1:0] i_cfg_wdata,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [1:0]        i_cmd,
    input  logic [FIDX_W-1:0] i_free_index,
    input  logic [ADDR_W-1:0] i_free_address,
    output logic              o_valid,
    output logic [1:0]        o_status,
    output logic [SIDX_W-1:0] o_slot_index,
    output t_addr             o_cpu_address,
    output t_addr             o_gpu_address,
    output logic [LIVE_W-1:0] o_live_count
);

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int KW = (CW > CAP_W) ? CW : CAP_W;
    localparam int PW = IW + SIZE_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;

    // configuration
    logic [CAP_W-1:0]  r_slot_capacity;
    logic [SIZE_W-1:0] r_slot_size;
    t_addr             r_cpu_base;
    t_addr             r_gpu_base;

    // control state
    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_free_depth, n_free_depth;
    logic [CW-1:0] r_next_fresh, n_next_fresh;
    logic [CW-1:0] r_allocated, n_allocated;

    // payload
    logic [IW-1:0] r_idx, n_idx;
    logic [PW-1:0] r_prod;

    logic              w_accept;
    logic [KW-1:0]     w_eff_cap;
    logic [KW-1:0]     w_cap_ext;
    logic [FIDX_W-1:0] w_rel_idx;
    logic              w_rel_ok;
    logic              w_emit;
    logic [1:0]        w_status;
    logic              w_alloc_ok;
    logic              w_mem_we;
    logic              w_mem_re;
    logic [IW-1:0]     w_mem_rdata;
    logic              w_div_start;
    logic              w_div_done;
    logic [OFF_W-1:0]  w_div_quo;
    logic [OFF_W-1:0]  w_offset;
    logic [31:0]       w_idx_ext;
    logic [31:0]       w_live_ext;

    dsa_stack #(
        .DEPTH (MAX_SLOTS),
        .WIDTH (IW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r_free_depth[IW-1:0]),
        .i_wdata (w_rel_idx[IW-1:0]),
        .i_re    (w_mem_re),
        .i_raddr (IW'(r_free_depth - 1'b1)),
        .o_rdata (w_mem_rdata)
    );

    assign w_offset = i_free_address[OFF_W-1:0] - r_gpu_base[OFF_W-1:0];

    dsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_offset),
        .i_divisor  (r_slot_size),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_capacity <= RST_CAPACITY;
            r_slot_size     <= RST_SIZE;
            r_cpu_base      <= '0;
            r_gpu_base      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CAPACITY: r_slot_capacity <= i_cfg_wdata[CAP_W-1:0];
                CFG_SIZE:     r_slot_size     <= i_cfg_wdata[SIZE_W-1:0];
                CFG_CPU_BASE: r_cpu_base      <= i_cfg_wdata;
                CFG_GPU_BASE: r_gpu_base      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_busy    = (r_state != S_IDLE);
    assign w_accept  = i_start && (r_state == S_IDLE);
    assign w_cap_ext = KW'(r_slot_capacity);
    assign w_eff_cap = (w_cap_ext > KW'(MAX_SLOTS)) ? KW'(MAX_SLOTS) : w_cap_ext;

    assign w_rel_idx = (r_state == S_DIV) ? w_div_quo : i_free_index;
    assign w_rel_ok  = (w_rel_idx < FIDX_W'(w_eff_cap)) && (r_allocated != '0) &&
                       (r_free_depth < CW'(MAX_SLOTS));

    always_comb begin
        n_state      = r_state;
        n_free_depth = r_free_depth;
        n_next_fresh = r_next_fresh;
        n_allocated  = r_allocated;
        n_idx        = r_idx;
        w_emit       = 1'b0;
        w_status     = ST_DONE;
        w_alloc_ok   = 1'b0;
        w_mem_we     = 1'b0;
        w_mem_re     = 1'b0;
        w_div_start  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_cmd)
                        CMD_ALLOC: begin
                            if (r_free_depth != '0) begin
                                w_mem_re     = 1'b1;
                                n_free_depth = r_free_depth - 1'b1;
                                n_allocated  = r_allocated + 1'b1;
                                n_state      = S_RD;
                            end else if (KW'(r_next_fresh) < w_eff_cap) begin
                                n_idx        = IW'(r_next_fresh);
                                n_next_fresh = r_next_fresh + 1'b1;
                                n_allocated  = r_allocated + 1'b1;
                                n_state      = S_MUL;
                            end else begin
                                w_emit   = 1'b1;
                                w_status = ST_EXHAUSTED;
                            end
                        end
                        CMD_FREE_IDX: begin
                            w_emit = 1'b1;
                            if (w_rel_ok) begin
                                w_mem_we     = 1'b1;
                                n_free_depth = r_free_depth + 1'b1;
                                n_allocated  = r_allocated - 1'b1;
                            end else begin
                                w_status = ST_INVALID;
                            end
                        end
                        CMD_FREE_ADDR: begin
                            if (r_slot_size == '0) begin
                                w_emit   = 1'b1;
                                w_status = ST_INVALID;
                            end else begin
                                w_div_start = 1'b1;
                                n_state     = S_DIV;
                            end
                        end
                        default: begin
                            // clear: stack contents are left, depth hides them
                            w_emit       = 1'b1;
                            n_free_depth = '0;
                            n_next_fresh = '0;
                            n_allocated  = '0;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_idx   = w_mem_rdata;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                w_emit     = 1'b1;
                w_alloc_ok = 1'b1;
                n_state    = S_IDLE;
            end
            S_DIV: begin
                if (w_div_done) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                    if (w_rel_ok) begin
                        w_mem_we     = 1'b1;
                        n_free_depth = r_free_depth + 1'b1;
                        n_allocated  = r_allocated - 1'b1;
                    end else begin
                        w_status = ST_INVALID;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_depth <= '0;
            r_next_fresh <= '0;
            r_allocated  <= '0;
        end else begin
            r_state      <= n_state;
            r_free_depth <= n_free_depth;
            r_next_fresh <= n_next_fresh;
            r_allocated  <= n_allocated;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (r_state == S_MUL) begin
            r_prod <= PW'(r_idx) * PW'(r_slot_size);
        end
    end

    assign w_idx_ext  = 32'(r_idx);
    assign w_live_ext = 32'(n_allocated);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_status     <= w_status;
            o_live_count <= w_live_ext[LIVE_W-1:0];
            if (w_alloc_ok) begin
                o_slot_index  <= w_idx_ext[SIDX_W-1:0];
                o_cpu_address <= r_cpu_base + ADDR_W'(r_prod);
                o_gpu_address <= r_gpu_base + ADDR_W'(r_prod);
            end else begin
                o_slot_index  <= '0;
                o_cpu_address <= '0;
                o_gpu_address <= '0;
            end
        end
    end

endmodule
